@@ rtl/gsa_pkg.sv @@
// Package for the generational slot allocator.
// Holds the operation codes. It depends on nothing.
`default_nettype none

package gsa_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_CHECK   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

endpackage

`default_nettype wire

@@ rtl/gsa_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// It depends on nothing and holds the allocator's free stack and slot table.
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/generational_slot_allocator_unit.sv @@
// Top level of the generational slot allocator.
// Depends on gsa_pkg and gsa_ram.
`default_nettype none

// Hands out handles (slot index plus generation) over a pool of SLOT_COUNT
// slots. func_i selects allocate, release or check; every item gives one
// result carrying ok, the granted handle on a successful allocate (zero
// otherwise) and the number of free slots left. After reset the block runs
// a clearing pass over every slot that loads the free stack and zeroes
// every slot entry; in_ready_o stays low during it. Then an allocate passes
// through S_TOP and S_EVAL, a release or check straight to S_EVAL, and the
// result is loaded into the output register in S_EVAL once that register
// is free. An allocate must read the free stack first, and the index it
// returns is the address of the slot table read that follows. The next
// item is taken the cycle after the previous result is loaded into the
// output register, so a result may still wait for out_ready_i while the
// next item is read; that item then holds until the output register is free.
module generational_slot_allocator_unit #(
  parameter int SLOT_COUNT = 256,
  parameter int GEN_BITS   = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  slot_index_i,
  input  wire logic [15:0] handle_generation_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             ok_o,
  output logic [7:0]       granted_index_o,
  output logic [15:0]      granted_generation_o,
  output logic [8:0]       free_count_o
);

  import gsa_pkg::*;

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int DEPTH_W = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_W  = GEN_BITS + 1;  // {active, generation}

  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(SLOT_COUNT - 1);
  localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_INIT,   // clearing pass after reset
    S_IDLE,   // wait for an item; stack top and slot entry are read here
    S_TOP,    // allocate: stack top is out, read its slot entry
    S_EVAL    // slot entry is out; commit once the output register is free
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   clr_q;
  logic [DEPTH_W-1:0] depth_q;
  func_e              op_q;
  logic [IDX_W-1:0]   tgt_q;       // slot the operation works on
  logic               in_range_q;
  logic [GEN_BITS-1:0] hgen_q;

  logic        out_valid_q;
  logic        out_ok_q;
  logic [7:0]  out_idx_q;
  logic [15:0] out_gen_q;
  logic [8:0]  out_free_q;

  // Memory ports
  logic              stk_we, stk_re;
  logic [IDX_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic              slt_we, slt_re;
  logic [IDX_W-1:0]  slt_waddr, slt_raddr;
  logic [SLOT_W-1:0] slt_wdata, slt_rdata;

  // Input views at the block's internal widths
  logic [31:0]         idx_ext, hgen_ext;
  logic [IDX_W-1:0]    in_addr;
  logic                in_range;
  logic [GEN_BITS-1:0] in_hgen;

  assign idx_ext  = 32'(slot_index_i);
  assign hgen_ext = 32'(handle_generation_i);
  assign in_addr  = idx_ext[IDX_W-1:0];
  assign in_range = idx_ext < 32'(SLOT_COUNT);
  assign in_hgen  = hgen_ext[GEN_BITS-1:0];

  // Evaluation of the slot entry read back
  logic                slot_active;
  logic [GEN_BITS-1:0] slot_gen, next_gen;
  logic                handle_ok, alloc_ok, release_ok, commit;
  logic [DEPTH_W-1:0]  depth_d;
  logic                res_ok;
  logic [31:0]         res_idx_ext, res_gen_ext, depth_ext;

  assign slot_active = slt_rdata[SLOT_W-1];
  assign slot_gen    = slt_rdata[GEN_BITS-1:0];
  assign next_gen    = slot_gen + GEN_BITS'(1);
  assign handle_ok   = in_range_q && slot_active && (slot_gen == hgen_q);
  assign alloc_ok    = (op_q == FUNC_ALLOC) && (depth_q != '0);
  assign release_ok  = (op_q == FUNC_RELEASE) && handle_ok && (depth_q < FULL_DEPTH);
  assign commit      = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);

  always_comb begin
    depth_d = depth_q;
    res_ok  = 1'b0;
    unique case (op_q)
      FUNC_ALLOC: begin
        res_ok = alloc_ok;
        if (alloc_ok) begin
          depth_d = depth_q - DEPTH_W'(1);
        end
      end
      FUNC_RELEASE: begin
        res_ok = release_ok;
        if (release_ok) begin
          depth_d = depth_q + DEPTH_W'(1);
        end
      end
      FUNC_CHECK: res_ok = handle_ok;
      FUNC_NONE:  res_ok = 1'b0;
      default:    res_ok = 1'b0;
    endcase
  end

  assign res_idx_ext = alloc_ok ? 32'(tgt_q) : 32'd0;
  assign res_gen_ext = alloc_ok ? 32'(next_gen) : 32'd0;
  assign depth_ext   = 32'(depth_d);

  // Free stack: cleared to descending indices, pushed on a good release.
  always_comb begin
    stk_re    = (state_q == S_IDLE);
    stk_raddr = IDX_W'(depth_q - DEPTH_W'(1));
    stk_we    = 1'b0;
    stk_waddr = clr_q;
    stk_wdata = LAST_IDX - clr_q;
    if (state_q == S_INIT) begin
      stk_we = 1'b1;
    end else if (commit && release_ok) begin
      stk_we    = 1'b1;
      stk_waddr = IDX_W'(depth_q);
      stk_wdata = tgt_q;
    end
  end

  // Slot table: read in IDLE at the handle, in TOP at the popped index.
  always_comb begin
    slt_re    = (state_q == S_IDLE) || (state_q == S_TOP);
    slt_raddr = (state_q == S_TOP) ? stk_rdata : in_addr;
    slt_we    = 1'b0;
    slt_waddr = clr_q;
    slt_wdata = '0;
    if (state_q == S_INIT) begin
      slt_we = 1'b1;
    end else if (commit && alloc_ok) begin
      slt_we    = 1'b1;
      slt_waddr = tgt_q;
      slt_wdata = {1'b1, next_gen};
    end else if (commit && release_ok) begin
      slt_we    = 1'b1;
      slt_waddr = tgt_q;
      slt_wdata = {1'b0, slot_gen};
    end
  end

  gsa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(SLOT_COUNT)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .re_i   (stk_re),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  gsa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slt_we),
    .waddr_i(slt_waddr),
    .wdata_i(slt_wdata),
    .re_i   (slt_re),
    .raddr_i(slt_raddr),
    .rdata_o(slt_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      depth_q     <= FULL_DEPTH;
      out_valid_q <= 1'b0;
    end else begin
      // A result taken in the same cycle as a commit is replaced below.
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == LAST_IDX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            op_q       <= func_e'(func_i);
            tgt_q      <= in_addr;
            in_range_q <= in_range;
            hgen_q     <= in_hgen;
            state_q    <= (func_e'(func_i) == FUNC_ALLOC) ? S_TOP : S_EVAL;
          end
        end
        S_TOP: begin
          tgt_q   <= stk_rdata;
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (commit) begin
            depth_q     <= depth_d;
            out_valid_q <= 1'b1;
            out_ok_q    <= res_ok;
            out_idx_q   <= res_idx_ext[7:0];
            out_gen_q   <= res_gen_ext[15:0];
            out_free_q  <= depth_ext[8:0];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_INIT;
      endcase
    end
  end

  assign out_valid_o          = out_valid_q;
  assign ok_o                 = out_ok_q;
  assign granted_index_o      = out_idx_q;
  assign granted_generation_o = out_gen_q;
  assign free_count_o         = out_free_q;

endmodule

`default_nettype wire

@@ rtl/gsa_checker.sv @@
// Port-level checks for the generational slot allocator, bound to its top.
// Depends only on the top level's ports.
`default_nettype none

module gsa_checker #(
  parameter int SLOT_COUNT = 256
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  func_i,
  input wire logic [7:0]  slot_index_i,
  input wire logic [15:0] handle_generation_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic        ok_o,
  input wire logic [7:0]  granted_index_o,
  input wire logic [15:0] granted_generation_o,
  input wire logic [8:0]  free_count_o
);

  // Result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(free_count_o) && $stable(ok_o))
    else $error("result dropped or changed while stalled");

  // One item at a time: busy right after an acceptance.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while the previous one is in flight");

  // A failed result carries a zero handle.
  a_zero_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> granted_index_o == 8'd0 && granted_generation_o == 16'd0)
    else $error("handle fields set on a failed result");

  // Free count never exceeds the pool.
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(free_count_o) <= SLOT_COUNT) || (SLOT_COUNT > 511))
    else $error("free count above pool size");

  // A stalled result is finally taken with the free count it was offered with.
  a_free_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && $past(out_valid_o) && $past(!out_ready_i)
    |-> $stable(free_count_o))
    else $error("free count changed under a stalled result");

endmodule

bind generational_slot_allocator_unit gsa_checker #(
  .SLOT_COUNT(SLOT_COUNT)
) u_gsa_checker (.*);

`default_nettype wire

@@ dv/gsa_checker.sv @@
// Checker for the generational slot allocator: watches both channels,
// predicts each result and compares it field by field.
// Depends on gsa_pkg for the operation codes.
`timescale 1ns / 1ps

module gsa_scoreboard #(
  parameter int SLOTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  func_i,
  input  wire logic [7:0]  slot_index_i,
  input  wire logic [15:0] handle_generation_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic        ok_i,
  input  wire logic [7:0]  granted_index_i,
  input  wire logic [15:0] granted_generation_i,
  input  wire logic [8:0]  free_count_i,
  output int               mismatches_o,
  output int               outstanding_o
);

  import gsa_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [7:0]  index;
    logic [15:0] generation;
    logic [8:0]  free;
  } answer_t;

  // Shadow of the pool.
  logic [7:0]  free_stack [SLOTS];
  logic [8:0]  free_depth;
  logic        slot_live  [SLOTS];
  logic [15:0] slot_gen   [SLOTS];

  answer_t answers_q[$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches_o++;
  endtask

  function automatic logic handle_ok(input logic [7:0] idx, input logic [15:0] gen);
    return slot_live[idx] && (slot_gen[idx] == gen);
  endfunction

  // Applies one item to the shadow pool and returns the answer it owes.
  function automatic answer_t pool_apply(input func_e op, input logic [7:0] idx,
                                         input logic [15:0] gen);
    answer_t    a;
    logic [7:0] top;
    a = '0;
    case (op)
      FUNC_ALLOC: begin
        if (free_depth != 9'd0) begin
          top = free_stack[free_depth - 9'd1];
          free_depth = free_depth - 9'd1;
          slot_gen[top]  = slot_gen[top] + 16'd1;
          slot_live[top] = 1'b1;
          a.ok = 1'b1;
          a.index = top;
          a.generation = slot_gen[top];
        end
      end
      FUNC_RELEASE: begin
        if (handle_ok(idx, gen) && free_depth < 9'(SLOTS)) begin
          slot_live[idx] = 1'b0;
          free_stack[free_depth] = idx;
          free_depth = free_depth + 9'd1;
          a.ok = 1'b1;
        end
      end
      FUNC_CHECK: a.ok = handle_ok(idx, gen);
      default: ;
    endcase
    a.free = free_depth;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    answer_t want;
    if (!rst_ni) begin
      for (int k = 0; k < SLOTS; k++) begin
        free_stack[k] = 8'(SLOTS - 1 - k);
        slot_live[k]  = 1'b0;
        slot_gen[k]   = 16'd0;
      end
      free_depth = 9'(SLOTS);
      answers_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = answers_q.pop_front();
          if (ok_i !== want.ok)
            report_mismatch($sformatf("ok %0b, want %0b", ok_i, want.ok));
          if (granted_index_i !== want.index)
            report_mismatch($sformatf("granted_index %0d, want %0d",
                                      granted_index_i, want.index));
          if (granted_generation_i !== want.generation)
            report_mismatch($sformatf("granted_generation %0d, want %0d",
                                      granted_generation_i, want.generation));
          if (free_count_i !== want.free)
            report_mismatch($sformatf("free_count %0d, want %0d",
                                      free_count_i, want.free));
        end
      end
      if (in_valid_i && in_ready_i)
        answers_q.push_back(pool_apply(func_e'(func_i), slot_index_i,
                                       handle_generation_i));
      outstanding_o <= answers_q.size();
    end
  end

endmodule

@@ dv/generational_slot_allocator_unit_test.sv @@
// Testbench top for generational_slot_allocator_unit: drives items, throttles
// the result side and gives the verdict. Depends on gsa_pkg, gsa_scoreboard and the RTL.
`timescale 1ns / 1ps

module generational_slot_allocator_unit_test;
  import gsa_pkg::*;

  localparam int SLOTS       = 256;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off in the pressure phase
  localparam int QUIET_LIMIT = 2000;  // covers the clearing pass and the hold-off

  typedef struct {
    logic [7:0]  idx;
    logic [15:0] gen;
  } handle_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [7:0]  slot_index;
  logic [15:0] handle_generation;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        ok;
  logic [7:0]  granted_index;
  logic [15:0] granted_generation;
  logic [8:0]  free_count;

  int mismatches;
  int outstanding;

  // Stimulus knobs, changed between phases.
  int idle_pct  = 0;
  int stall_pct = 0;

  logic hold_go   = 1'b0;
  int   hold_left = HOLD_CYCLES;

  logic in_fire = 1'b0;  // item taken at the last rising edge
  int   quiet   = 0;

  // Handles learned from granted results; released ones move to stale.
  handle_t live_q[$];
  handle_t stale_q[$];

  always #5 clk_i = ~clk_i;

  generational_slot_allocator_unit #(
    .SLOT_COUNT(SLOTS),
    .GEN_BITS  (16)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .func_i              (func),
    .slot_index_i        (slot_index),
    .handle_generation_i (handle_generation),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .ok_o                (ok),
    .granted_index_o     (granted_index),
    .granted_generation_o(granted_generation),
    .free_count_o        (free_count)
  );

  gsa_scoreboard #(.SLOTS(SLOTS)) u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .func_i              (func),
    .slot_index_i        (slot_index),
    .handle_generation_i (handle_generation),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .ok_i                (ok),
    .granted_index_i     (granted_index),
    .granted_generation_i(granted_generation),
    .free_count_i        (free_count),
    .mismatches_o        (mismatches),
    .outstanding_o       (outstanding)
  );

  // Handshake sampling and the watchdog. A quiet count reaching QUIET_LIMIT,
  // with neither channel moving, means the block is stuck.
  always @(posedge clk_i) begin
    in_fire <= in_valid && in_ready;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet + 1 >= QUIET_LIMIT) begin
        $display("** generational_slot_allocator_unit: FAILED **");
        $finish;
      end
    end
  end

  // Learn handles from granted results. A successful grant never carries
  // generation zero here: a wrap would need 65536 reuses of one slot.
  always @(posedge clk_i) begin
    if (out_valid && out_ready && ok && granted_generation != 16'd0)
      live_q.push_back('{idx: granted_index, gen: granted_generation});
  end

  // Result side. The hold-off is counted here once requested; otherwise
  // ready drops at random with the current stall rate.
  always @(negedge clk_i) begin
    if (hold_go && hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offers one item at a falling edge and returns at the falling edge after
  // it was taken, so a following item can go out with valid left high.
  task automatic send_item(input func_e op, input logic [7:0] idx,
                           input logic [15:0] gen);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid          <= 1'b1;
    func              <= op;
    slot_index        <= idx;
    handle_generation <= gen;
    do @(negedge clk_i); while (!in_fire);
  endtask

  // Mostly real handles, some stale, some with one generation bit flipped,
  // and a few fully random ones. A release consumes the live handle.
  task automatic draw_handle(input bit consume, output logic [7:0] idx,
                             output logic [15:0] gen);
    int r;
    int k;
    r = $urandom_range(0, 99);
    idx = 8'($urandom);
    gen = 16'($urandom);
    if (r < 70 && live_q.size() > 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      idx = live_q[k].idx;
      gen = live_q[k].gen;
      if (consume) begin
        stale_q.push_back(live_q[k]);
        live_q.delete(k);
      end
    end else if (r < 85 && stale_q.size() > 0) begin
      k = $urandom_range(0, stale_q.size() - 1);
      idx = stale_q[k].idx;
      gen = stale_q[k].gen;
    end else if (r < 93 && live_q.size() > 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      idx = live_q[k].idx;
      gen = live_q[k].gen ^ (16'd1 << $urandom_range(0, 15));
    end
  endtask

  // One random item from the given mix of allocate / release / check;
  // whatever is left over goes to the unused code.
  task automatic random_item(input int alloc_pct, input int rel_pct, input int chk_pct);
    int          r;
    logic [7:0]  idx;
    logic [15:0] gen;
    r = $urandom_range(0, 99);
    idx = 8'($urandom);
    gen = 16'($urandom);
    if (r < alloc_pct) begin
      send_item(FUNC_ALLOC, idx, gen);  // fields ignored, random content
    end else if (r < alloc_pct + rel_pct) begin
      draw_handle(1'b1, idx, gen);
      send_item(FUNC_RELEASE, idx, gen);
    end else if (r < alloc_pct + rel_pct + chk_pct) begin
      draw_handle(1'b0, idx, gen);
      send_item(FUNC_CHECK, idx, gen);
    end else begin
      send_item(FUNC_NONE, idx, gen);
    end
  endtask

  task automatic run_phase(input int n, input int idle, input int stall,
                           input int alloc_pct, input int rel_pct, input int chk_pct);
    idle_pct  = idle;
    stall_pct <= stall;
    repeat (n) random_item(alloc_pct, rel_pct, chk_pct);
  endtask

  initial begin
    in_valid          = 1'b0;
    func              = FUNC_NONE;
    slot_index        = 8'd0;
    handle_generation = 16'd0;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: first grants come off the top of the stack as 0, 1, 2 with
    // generation 1; the allocate fields carry extreme values that must be
    // ignored.
    send_item(FUNC_ALLOC,   8'hFF, 16'hFFFF);
    send_item(FUNC_ALLOC,   8'h00, 16'h0000);
    send_item(FUNC_ALLOC,   8'hAA, 16'h5555);
    send_item(FUNC_CHECK,   8'd0,  16'd1);     // valid handle
    send_item(FUNC_CHECK,   8'd0,  16'd2);     // generation mismatch
    send_item(FUNC_CHECK,   8'd255, 16'd0);    // never allocated
    send_item(FUNC_CHECK,   8'd255, 16'hFFFF);
    send_item(FUNC_RELEASE, 8'd1,  16'd1);     // accepted
    send_item(FUNC_RELEASE, 8'd1,  16'd1);     // repeated release
    send_item(FUNC_CHECK,   8'd1,  16'd1);     // stale now
    send_item(FUNC_ALLOC,   8'd0,  16'd0);     // slot 1 again, generation 2
    send_item(FUNC_RELEASE, 8'd1,  16'd1);     // stale generation
    send_item(FUNC_RELEASE, 8'd0,  16'hFFFF);  // wrong generation
    send_item(FUNC_RELEASE, 8'd255, 16'd0);    // inactive slot
    send_item(FUNC_NONE,    8'hFF, 16'hFFFF);  // unused code
    send_item(FUNC_NONE,    8'h00, 16'h0000);
    send_item(FUNC_CHECK,   8'd1,  16'd2);
    send_item(FUNC_RELEASE, 8'd2,  16'd1);
    send_item(FUNC_RELEASE, 8'd0,  16'd1);
    send_item(FUNC_ALLOC,   8'h55, 16'hAAAA);

    // Random phases: no throttling; an allocate-heavy drain past an empty pool
    // with the sender idle; release-heavy with the receiver stalling; both
    // throttled; and a balanced phase under a long receiver hold-off.
    run_phase(300, 0,  0,  40, 30, 25);
    run_phase(350, 67, 0,  90, 3,  5);
    run_phase(300, 0,  67, 20, 55, 20);
    run_phase(300, 11, 11, 40, 30, 25);
    hold_go <= 1'b1;
    run_phase(200, 0,  0,  40, 30, 25);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("** generational_slot_allocator_unit: PASSED **");
    end else begin
      $display("** generational_slot_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ generational_slot_allocator_unit.f @@
rtl/gsa_pkg.sv
rtl/gsa_ram.sv
rtl/generational_slot_allocator_unit.sv
rtl/gsa_checker.sv
dv/gsa_checker.sv
dv/generational_slot_allocator_unit_test.sv
